### src/pidc_pkg.sv
// shared types, constants and register codes for the clamped pid controller
package pidc_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int MUL_DIGIT_W   = 16;

	localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	localparam logic STAT_OK       = 1'b0;
	localparam logic STAT_BAD_STEP = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_OUT_FLOOR  = 3'd3,
		REG_OUT_CEIL   = 3'd4,
		REG_INT_FLOOR  = 3'd5,
		REG_INT_CEIL   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                     action;
		logic signed [DATA_W-1:0] target;
		logic signed [DATA_W-1:0] measured;
		logic signed [DATA_W-1:0] step_time;
	} upd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic signed [DATA_W-1:0] integral_now;
		logic signed [DATA_W-1:0] last_error;
		logic                     status;
	} res_t;

endpackage

### src/pidc_mul.sv
// shared fixed point multiplier, one 16-bit digit of the first operand per cycle
module pidc_mul #(
	parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  start,
	input  logic signed [pidc_pkg::DATA_W-1:0]                    a,
	input  logic signed [pidc_pkg::DATA_W+FRAC_BITS:0]            b,
	output logic                                                  done,
	output logic signed [2*pidc_pkg::DATA_W:0]                    result
);
	import pidc_pkg::*;

	localparam int DW   = DATA_W + FRAC_BITS + 1;
	localparam int ND   = (DATA_W + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
	localparam int PADW = ND * MUL_DIGIT_W;
	localparam int ACCW = PADW + DW;
	localparam int RW   = DATA_W + DW - FRAC_BITS + 1;
	localparam int CW   = (ND > 1) ? $clog2(ND) : 1;

	typedef enum logic [1:0] {
		M_IDLE,
		M_RUN,
		M_FIN
	} mstate_t;

	mstate_t                     state_q;
	logic [CW-1:0]               cnt_q;
	logic [PADW-1:0]             ma_q;
	logic [DW-1:0]               mb_q;
	logic                        neg_q;
	logic [ACCW-1:0]             acc_q;
	logic                        done_q;
	logic signed [RW-1:0]        result_q;

	logic [DATA_W-1:0]           mag_a;
	logic [DW-1:0]               mag_b;
	logic [MUL_DIGIT_W-1:0]      digit;
	logic [MUL_DIGIT_W+DW-1:0]   pp;
	logic signed [RW-1:0]        mag_ext;

	always_comb begin
		mag_a   = a[DATA_W-1] ? (~a + 1'b1) : a;
		mag_b   = b[DW-1] ? (~b + 1'b1) : b;
		digit   = ma_q[PADW-1 -: MUL_DIGIT_W];
		pp      = digit * mb_q;
		mag_ext = {1'b0, acc_q[FRAC_BITS +: RW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						ma_q    <= PADW'(mag_a);
						mb_q    <= mag_b;
						neg_q   <= a[DATA_W-1] ^ b[DW-1];
						acc_q   <= '0;
						cnt_q   <= CW'(ND - 1);
						state_q <= M_RUN;
					end
				end
				M_RUN: begin
					acc_q <= (acc_q << MUL_DIGIT_W) + ACCW'(pp);
					ma_q  <= ma_q << MUL_DIGIT_W;
					if (cnt_q == '0) begin
						state_q <= M_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				M_FIN: begin
					result_q <= neg_q ? -mag_ext : mag_ext;
					done_q   <= 1'b1;
					state_q  <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = (2*DATA_W+1)'(result_q);

endmodule

### src/pidc_div.sv
// radix-4 restoring divider for the derivative term
module pidc_div #(
	parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic [pidc_pkg::DATA_W-1:0]                diff_mag,
	input  logic                                       neg,
	input  logic [pidc_pkg::DATA_W-1:0]                divisor,
	output logic                                       done,
	output logic signed [pidc_pkg::DATA_W+FRAC_BITS:0] quot
);
	import pidc_pkg::*;

	localparam int QW = DATA_W + FRAC_BITS;
	localparam int NS = (QW + 1) / 2;
	localparam int NW = 2 * NS;
	localparam int DW = QW + 1;
	localparam int CW = $clog2(NS);

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_FIN
	} dstate_t;

	dstate_t              state_q;
	logic [CW-1:0]        cnt_q;
	logic [NW-1:0]        num_q;
	logic [NW-1:0]        quo_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    d_q;
	logic                 neg_q;
	logic                 done_q;
	logic signed [DW-1:0] quot_q;

	logic [DATA_W-1:0]    r1;
	logic [DATA_W-1:0]    r1n;
	logic [DATA_W-1:0]    r2;
	logic [DATA_W-1:0]    r2n;
	logic                 ge1;
	logic                 ge2;
	logic signed [DW-1:0] q_ext;

	always_comb begin
		r1    = {rem_q[DATA_W-2:0], num_q[NW-1]};
		ge1   = (r1 >= d_q);
		r1n   = ge1 ? (r1 - d_q) : r1;
		r2    = {r1n[DATA_W-2:0], num_q[NW-2]};
		ge2   = (r2 >= d_q);
		r2n   = ge2 ? (r2 - d_q) : r2;
		q_ext = {1'b0, quo_q[QW-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						num_q   <= NW'(diff_mag) << FRAC_BITS;
						quo_q   <= '0;
						rem_q   <= '0;
						d_q     <= divisor;
						neg_q   <= neg;
						cnt_q   <= CW'(NS - 1);
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= r2n;
					quo_q <= {quo_q[NW-3:0], ge1, ge2};
					num_q <= num_q << 2;
					if (cnt_q == '0) begin
						state_q <= D_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				D_FIN: begin
					quot_q  <= neg_q ? -q_ext : q_ext;
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### src/pid_controller_clamped_top.sv
// clamped pid controller top level: registers, sequencer and result register
// An update runs each of its four products through the shared multiplier as two 16-bit
// digits, and the derivative divide through the radix-4 divider. The first update after
// reset or a clear skips the divide; a clear or a non-positive step time skips all the
// arithmetic and goes straight to the output register. upd_stall is high from the
// transfer of an item until its result is loaded into the output register, and a
// result waiting on res_stall does not hold back the next item's arithmetic.
module pid_controller_clamped_top #(
	parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pidc_pkg::DATA_W-1:0]         cfg_data,
	input  logic                                upd_valid,
	output logic                                upd_stall,
	input  pidc_pkg::upd_t                      upd,
	output logic                                res_valid,
	input  logic                                res_stall,
	output pidc_pkg::res_t                      res
);
	import pidc_pkg::*;

	localparam int DW = DATA_W + FRAC_BITS + 1;
	localparam int RW = 2 * DATA_W + 1;
	localparam int IW = RW + 1;
	localparam int SW = RW + 2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_DT,
		S_DIV,
		S_MUL_P,
		S_MUL_I,
		S_MUL_D,
		S_CLAMP,
		S_OUT
	} state_t;

	state_t                   state_q;
	logic signed [DATA_W-1:0] gain_p_q;
	logic signed [DATA_W-1:0] gain_i_q;
	logic signed [DATA_W-1:0] gain_d_q;
	logic signed [DATA_W-1:0] out_floor_q;
	logic signed [DATA_W-1:0] out_ceil_q;
	logic signed [DATA_W-1:0] int_floor_q;
	logic signed [DATA_W-1:0] int_ceil_q;
	logic signed [DATA_W-1:0] prior_q;
	logic signed [DATA_W-1:0] integral_q;
	logic                     first_q;
	logic signed [DATA_W-1:0] e_q;
	logic signed [DATA_W-1:0] dt_q;
	logic signed [DW-1:0]     deriv_q;
	logic signed [SW-1:0]     sum_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     status_q;
	logic                     mul_start_q;
	logic signed [DATA_W-1:0] mul_a_q;
	logic signed [DW-1:0]     mul_b_q;
	logic                     div_start_q;
	logic                     res_valid_q;
	res_t                     res_q;

	logic                     mul_done;
	logic signed [RW-1:0]     mul_res;
	logic                     div_done;
	logic signed [DW-1:0]     div_quot;

	logic                     upd_xfer;
	logic                     step_bad;
	logic [DATA_W:0]          e_full;
	logic signed [DATA_W-1:0] e_sat;
	logic [DATA_W:0]          diff;
	logic                     diff_neg;
	logic [DATA_W-1:0]        diff_mag;
	logic signed [IW-1:0]     isum;
	logic signed [IW-1:0]     ilim;
	logic signed [SW-1:0]     olim;
	logic signed [SW-1:0]     sum_next;
	logic                     res_free;

	always_comb begin
		upd_xfer = upd_valid && !upd_stall;
		step_bad = upd.step_time[DATA_W-1] || (upd.step_time == '0);
		e_full   = {upd.target[DATA_W-1], upd.target} - {upd.measured[DATA_W-1], upd.measured};
		if (e_full[DATA_W] != e_full[DATA_W-1]) begin
			e_sat = e_full[DATA_W] ? DATA_MIN : DATA_MAX;
		end else begin
			e_sat = e_full[DATA_W-1:0];
		end
		diff     = {e_q[DATA_W-1], e_q} - {prior_q[DATA_W-1], prior_q};
		diff_neg = diff[DATA_W];
		diff_mag = diff_neg ? DATA_W'(-diff) : diff[DATA_W-1:0];

		isum = IW'(integral_q) + IW'(mul_res);
		ilim = isum;
		if (IW'(int_ceil_q) < ilim) begin
			ilim = IW'(int_ceil_q);
		end
		if (ilim < IW'(int_floor_q)) begin
			ilim = IW'(int_floor_q);
		end

		sum_next = sum_q + SW'(mul_res);

		olim = sum_q;
		if (SW'(out_ceil_q) < olim) begin
			olim = SW'(out_ceil_q);
		end
		if (olim < SW'(out_floor_q)) begin
			olim = SW'(out_floor_q);
		end

		res_free = !res_valid_q || !res_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			out_floor_q <= DATA_MIN;
			out_ceil_q  <= DATA_MAX;
			int_floor_q <= DATA_MIN;
			int_ceil_q  <= DATA_MAX;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN_P:    gain_p_q    <= cfg_data;
				REG_GAIN_I:    gain_i_q    <= cfg_data;
				REG_GAIN_D:    gain_d_q    <= cfg_data;
				REG_OUT_FLOOR: out_floor_q <= cfg_data;
				REG_OUT_CEIL:  out_ceil_q  <= cfg_data;
				REG_INT_FLOOR: int_floor_q <= cfg_data;
				REG_INT_CEIL:  int_ceil_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prior_q     <= '0;
			integral_q  <= '0;
			first_q     <= 1'b1;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (upd_xfer) begin
						if (upd.action == ACT_CLEAR) begin
							prior_q    <= '0;
							integral_q <= '0;
							first_q    <= 1'b1;
							drive_q    <= '0;
							status_q   <= STAT_OK;
							state_q    <= S_OUT;
						end else if (step_bad) begin
							drive_q  <= '0;
							status_q <= STAT_BAD_STEP;
							state_q  <= S_OUT;
						end else begin
							e_q         <= e_sat;
							dt_q        <= upd.step_time;
							mul_a_q     <= e_sat;
							mul_b_q     <= DW'(upd.step_time);
							mul_start_q <= 1'b1;
							state_q     <= S_MUL_DT;
						end
					end
				end
				S_MUL_DT: begin
					if (mul_done) begin
						integral_q <= ilim[DATA_W-1:0];
						if (first_q) begin
							deriv_q     <= '0;
							sum_q       <= '0;
							mul_a_q     <= gain_p_q;
							mul_b_q     <= DW'(e_q);
							mul_start_q <= 1'b1;
							state_q     <= S_MUL_P;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						deriv_q     <= div_quot;
						sum_q       <= '0;
						mul_a_q     <= gain_p_q;
						mul_b_q     <= DW'(e_q);
						mul_start_q <= 1'b1;
						state_q     <= S_MUL_P;
					end
				end
				S_MUL_P: begin
					if (mul_done) begin
						sum_q       <= sum_next;
						mul_a_q     <= gain_i_q;
						mul_b_q     <= DW'(integral_q);
						mul_start_q <= 1'b1;
						state_q     <= S_MUL_I;
					end
				end
				S_MUL_I: begin
					if (mul_done) begin
						sum_q       <= sum_next;
						mul_a_q     <= gain_d_q;
						mul_b_q     <= deriv_q;
						mul_start_q <= 1'b1;
						state_q     <= S_MUL_D;
					end
				end
				S_MUL_D: begin
					if (mul_done) begin
						sum_q   <= sum_next;
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					drive_q  <= olim[DATA_W-1:0];
					prior_q  <= e_q;
					first_q  <= 1'b0;
					status_q <= STAT_OK;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (res_free) begin
						res_q.drive        <= drive_q;
						res_q.integral_now <= integral_q;
						res_q.last_error   <= prior_q;
						res_q.status       <= status_q;
						res_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	pidc_mul #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.result (mul_res)
	);

	pidc_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.diff_mag (diff_mag),
		.neg      (diff_neg),
		.divisor  (dt_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign upd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL_DT || state_q == S_MUL_P ||
			state_q == S_MUL_I || state_q == S_MUL_D))
		else $error("multiplier finished outside a multiply step");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide step");

	a_first_no_deriv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL_D && first_q) |-> (deriv_q == '0))
		else $error("derivative used on the first update");

	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_xfer && upd.action == ACT_CLEAR) |=> (integral_q == '0 && prior_q == '0 && first_q))
		else $error("clear transfer left controller state");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && res_free) |=> (res_valid && state_q == S_IDLE))
		else $error("result not loaded into output register");

endmodule
